// ===== hdl/luhn_pkg.sv =====
// Shared widths, result codes and the status struct of the Luhn card number classifier.
// Used by luhn_bcd_conv, luhn_digit_scan and luhn_card_number_classifier; no dependencies.
package luhn_pkg;

    // Width of the binary card number.
    localparam int CARD_W = 54;
    // Decimal digits that a CARD_W-bit number can have (2**54 - 1 has 17 digits).
    localparam int BCD_DIGITS = 17;
    localparam int BCD_W = 4 * BCD_DIGITS;
    // Default for the longest number that still gets a Luhn sum.
    localparam int MAX_DIGITS_DEF = 16;

    localparam int BRAND_W = 2;
    localparam int COUNT_W = 5;
    localparam int SUM_W = 8;

    typedef enum logic [BRAND_W-1:0] {
        BRAND_INVALID  = 2'd0,
        BRAND_PFX34_37 = 2'd1,
        BRAND_PFX51_55 = 2'd2,
        BRAND_PFX4     = 2'd3
    } luhn_brand_t;

    // Status that each serial unit reports to the sequencer.
    typedef struct packed {
        logic busy;
        logic done;
    } luhn_status_t;

endpackage

// ===== hdl/luhn_bcd_conv.sv =====
// Bit-serial binary to BCD converter (shift and add-3), one input bit per cycle.
// Depends on luhn_pkg for the card and BCD widths and the status struct.
module luhn_bcd_conv
    import luhn_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                start,
    input  logic [CARD_W-1:0]   number,
    output logic [BCD_W-1:0]    bcd,
    output luhn_status_t        status
);

    localparam int CNT_W = $clog2(CARD_W);

    logic [CARD_W-1:0] bin_reg;
    logic [BCD_W-1:0]  bcd_reg;
    logic [BCD_W-1:0]  adj;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    // Every BCD digit of five or more gets three added before the shift.
    always_comb begin
        for (int i = 0; i < BCD_DIGITS; i++) begin
            if (bcd_reg[4*i +: 4] >= 4'd5) begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4] + 4'd3;
            end else begin
                adj[4*i +: 4] = bcd_reg[4*i +: 4];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && cnt_reg == CNT_W'(CARD_W - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            bin_reg <= number;
            bcd_reg <= '0;
            cnt_reg <= '0;
        end else if (busy_reg) begin
            bcd_reg <= {adj[BCD_W-2:0], bin_reg[CARD_W-1]};
            bin_reg <= {bin_reg[CARD_W-2:0], 1'b0};
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

    assign bcd = bcd_reg;
    assign status = '{busy: busy_reg, done: done_reg};

endmodule

// ===== hdl/luhn_digit_scan.sv =====
// Digit-serial Luhn accumulator: walks the BCD digits from the right, one per cycle,
// forming the sum, the sum modulo ten, the digit count and the two leading digits.
// Depends on luhn_pkg.
module luhn_digit_scan
    import luhn_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [BCD_W-1:0]   bcd,
    output logic [COUNT_W-1:0] digit_count,
    output logic [SUM_W-1:0]   sum,
    output logic               mod_zero,
    output logic [3:0]         lead_hi,
    output logic [3:0]         lead_lo,
    output luhn_status_t       status
);

    localparam int POS_W = $clog2(BCD_DIGITS);

    logic [BCD_W-1:0]   dig_reg;
    logic [POS_W-1:0]   pos_reg;
    logic [SUM_W-1:0]   sum_reg;
    logic [3:0]         mod_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [3:0]         hi_reg;
    logic [3:0]         lo_reg;
    logic [3:0]         prev_reg;
    logic               busy_reg;
    logic               done_reg;

    logic [3:0] d;
    logic [4:0] dbl;
    logic [3:0] dd;
    logic [4:0] msum;
    logic [3:0] mod_next;

    // Digits at odd positions are doubled; a doubled value of ten or more
    // drops to its digit sum.
    always_comb begin
        d   = dig_reg[3:0];
        dbl = {d, 1'b0};
        if (!pos_reg[0]) begin
            dd = d;
        end else if (dbl >= 5'd10) begin
            dd = 4'(dbl - 5'd9);
        end else begin
            dd = dbl[3:0];
        end
        msum = {1'b0, mod_reg} + {1'b0, dd};
        if (msum >= 5'd10) begin
            mod_next = 4'(msum - 5'd10);
        end else begin
            mod_next = msum[3:0];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
            end else if (busy_reg && pos_reg == POS_W'(BCD_DIGITS - 1)) begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            dig_reg   <= bcd;
            pos_reg   <= '0;
            sum_reg   <= '0;
            mod_reg   <= '0;
            count_reg <= '0;
            hi_reg    <= '0;
            lo_reg    <= '0;
            prev_reg  <= '0;
        end else if (busy_reg) begin
            dig_reg  <= {4'd0, dig_reg[BCD_W-1:4]};
            pos_reg  <= pos_reg + 1'b1;
            sum_reg  <= sum_reg + SUM_W'(dd);
            mod_reg  <= mod_next;
            prev_reg <= d;
            // The most significant nonzero digit seen so far sets the count
            // and the leading pair.
            if (d != 4'd0) begin
                count_reg <= COUNT_W'(pos_reg + 1'b1);
                hi_reg    <= d;
                lo_reg    <= prev_reg;
            end
        end
    end

    assign digit_count = count_reg;
    assign sum         = sum_reg;
    assign mod_zero    = (mod_reg == 4'd0);
    assign lead_hi     = hi_reg;
    assign lead_lo     = lo_reg;
    assign status      = '{busy: busy_reg, done: done_reg};

endmodule

// ===== hdl/luhn_card_number_classifier.sv =====
// Top level of the Luhn card number classifier: sequencer, classification and result register.
// Depends on luhn_pkg, luhn_bcd_conv and luhn_digit_scan.
//
//   channel  direction  handshake            payload
//   s_       in         s_valid / s_ready    s_card_number[53:0]
//   m_       out        m_valid / m_ready    m_brand[1:0], m_luhn_ok, m_digit_count[4:0],
//                                            m_luhn_sum[7:0]
//
// A beat goes from acceptance to the result register through the bit-serial binary to BCD
// converter (one input bit per cycle), a handover to the digit scan, the digit scan (one
// decimal digit per cycle) and a load, which waits while the previous result is stalled.
// Reset is synchronous and active low; it clears the sequencer and the valid flags.
// A new beat is taken as soon as the sequencer is idle, even while the previous result
// still waits in the output register; a stalled result only holds the finished scan.
module luhn_card_number_classifier
    import luhn_pkg::*;
#(
    parameter int MAX_DIGITS = MAX_DIGITS_DEF
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  logic [CARD_W-1:0]  s_card_number,
    output logic               m_valid,
    input  logic               m_ready,
    output logic [BRAND_W-1:0] m_brand,
    output logic               m_luhn_ok,
    output logic [COUNT_W-1:0] m_digit_count,
    output logic [SUM_W-1:0]   m_luhn_sum
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONV,
        ST_SCAN,
        ST_HOLD
    } state_t;

    state_t state_reg;

    logic               m_valid_reg;
    logic [BRAND_W-1:0] brand_reg;
    logic               ok_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [SUM_W-1:0]   sum_reg;

    logic [BCD_W-1:0]   bcd;
    luhn_status_t       conv_status;
    luhn_status_t       scan_status;
    logic [COUNT_W-1:0] scan_count;
    logic [SUM_W-1:0]   scan_sum;
    logic               scan_mod_zero;
    logic [3:0]         lead_hi;
    logic [3:0]         lead_lo;

    logic               accept;
    logic               result_free;
    logic               load;
    logic               too_long;
    logic               ok_next;
    logic [SUM_W-1:0]   sum_next;
    luhn_brand_t        brand_next;

    assign s_ready     = (state_reg == ST_IDLE);
    assign accept      = s_valid && s_ready;
    assign result_free = !m_valid_reg || m_ready;

    // The result register loads when the scan has finished and the previous
    // result is gone or leaves in this very cycle.
    assign load = result_free &&
                  ((state_reg == ST_SCAN && scan_status.done) || state_reg == ST_HOLD);

    luhn_bcd_conv u_conv (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (accept),
        .number  (s_card_number),
        .bcd     (bcd),
        .status  (conv_status)
    );

    luhn_digit_scan u_scan (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .start       (conv_status.done),
        .bcd         (bcd),
        .digit_count (scan_count),
        .sum         (scan_sum),
        .mod_zero    (scan_mod_zero),
        .lead_hi     (lead_hi),
        .lead_lo     (lead_lo),
        .status      (scan_status)
    );

    // Numbers longer than MAX_DIGITS keep their true digit count but get no sum,
    // fail the check and are never classed. The brand tests need at least 13 digits,
    // so numbers with fewer than two digits fall out as invalid by themselves.
    always_comb begin
        too_long   = (scan_count > COUNT_W'(MAX_DIGITS));
        ok_next    = !too_long && scan_mod_zero;
        sum_next   = too_long ? '0 : scan_sum;
        brand_next = BRAND_INVALID;
        if (ok_next) begin
            if (lead_hi == 4'd3 && (lead_lo == 4'd4 || lead_lo == 4'd7) &&
                scan_count == COUNT_W'(15)) begin
                brand_next = BRAND_PFX34_37;
            end else if (lead_hi == 4'd5 && lead_lo >= 4'd1 && lead_lo <= 4'd5 &&
                         scan_count == COUNT_W'(16)) begin
                brand_next = BRAND_PFX51_55;
            end else if (lead_hi == 4'd4 &&
                         (scan_count == COUNT_W'(13) || scan_count == COUNT_W'(16))) begin
                brand_next = BRAND_PFX4;
            end
        end
    end

    // Sequencer and result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            if (load) begin
                m_valid_reg <= 1'b1;
                brand_reg   <= brand_next;
                ok_reg      <= ok_next;
                count_reg   <= scan_count;
                sum_reg     <= sum_next;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end

            case (state_reg)
                ST_IDLE: begin
                    if (accept) begin
                        state_reg <= ST_CONV;
                    end
                end
                ST_CONV: begin
                    if (conv_status.done) begin
                        state_reg <= ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (scan_status.done) begin
                        state_reg <= load ? ST_IDLE : ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (load) begin
                        state_reg <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_brand       = brand_reg;
    assign m_luhn_ok     = ok_reg;
    assign m_digit_count = count_reg;
    assign m_luhn_sum    = sum_reg;

    // A new result appears only right after a finished scan.
    a_result_after_scan: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> ($past(state_reg) == ST_SCAN || $past(state_reg) == ST_HOLD))
        else $error("result register loaded outside the end of a scan");

    // While the input side is open, neither serial unit may be running.
    a_idle_units: assert property (@(posedge aclk) disable iff (!aresetn)
        s_ready |-> (!conv_status.busy && !scan_status.busy))
        else $error("input ready while a serial unit is busy");

    // A classed number has always passed the check.
    a_brand_needs_ok: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_brand != BRAND_INVALID) |-> m_luhn_ok)
        else $error("brand given to a number that failed the check");

    // A passing number is never longer than the accepted length.
    a_ok_length: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && m_luhn_ok) |-> (m_digit_count <= COUNT_W'(MAX_DIGITS)))
        else $error("check passed for an overlong number");

    // The scan is started only by the converter's completion.
    a_scan_start: assert property (@(posedge aclk) disable iff (!aresetn)
        conv_status.done |-> state_reg == ST_CONV)
        else $error("conversion finished outside the conversion phase");

endmodule

// ===== tb/tb_luhn_card_number_classifier.sv =====
// Self-checking testbench for luhn_card_number_classifier: directed and random card numbers,
// a scoreboard class that predicts each result, and random idling on both channels.
// Depends on luhn_pkg and the luhn_card_number_classifier RTL.

// Holds the verdicts expected for accepted card numbers, oldest first, and compares each
// result beat against the oldest one.
class luhn_scoreboard;

    typedef struct {
        bit [luhn_pkg::CARD_W-1:0]  card;
        luhn_pkg::luhn_brand_t      brand;
        bit                         luhn_ok;
        bit [luhn_pkg::COUNT_W-1:0] digit_count;
        bit [luhn_pkg::SUM_W-1:0]   luhn_sum;
    } card_verdict_t;

    card_verdict_t pending_verdicts[$];
    int unsigned   error_count;

    function new();
        error_count = 0;
    endfunction

    // Splits the number into decimal digits, forms the mod-10 sum with every second digit
    // from the right doubled, and classes a passing number by its leading digits and length.
    static function card_verdict_t classify(bit [luhn_pkg::CARD_W-1:0] card);
        card_verdict_t v;
        bit [63:0]     rest;
        int unsigned   digit [0:23];
        int unsigned   n;
        int unsigned   total;
        int unsigned   d;
        int unsigned   lead;
        int unsigned   p;
        v.card        = card;
        v.brand       = luhn_pkg::BRAND_INVALID;
        v.luhn_ok     = 1'b0;
        v.digit_count = '0;
        v.luhn_sum    = '0;
        rest  = 64'(card);
        n     = 0;
        total = 0;
        while (rest != 0) begin
            digit[n] = int'(rest % 10);
            rest     = rest / 10;
            n++;
        end
        v.digit_count = n[luhn_pkg::COUNT_W-1:0];
        // Numbers longer than the supported length get no sum and no check.
        if (n <= luhn_pkg::MAX_DIGITS_DEF) begin
            for (p = 0; p < n; p++) begin
                d = digit[p];
                if (p[0]) begin
                    d = d * 2;
                    if (d >= 10)
                        d = d - 9;
                end
                total += d;
            end
            v.luhn_sum = total[luhn_pkg::SUM_W-1:0];
            v.luhn_ok  = (total % 10 == 0);
            if (v.luhn_ok && n >= 2) begin
                lead = digit[n-1] * 10 + digit[n-2];
                if ((lead == 34 || lead == 37) && n == 15)
                    v.brand = luhn_pkg::BRAND_PFX34_37;
                else if (lead >= 51 && lead <= 55 && n == 16)
                    v.brand = luhn_pkg::BRAND_PFX51_55;
                else if (lead / 10 == 4 && (n == 13 || n == 16))
                    v.brand = luhn_pkg::BRAND_PFX4;
            end
        end
        return v;
    endfunction

    // Luhn sum that the block reports for the given number.
    function int unsigned luhn_sum_of(bit [luhn_pkg::CARD_W-1:0] card);
        card_verdict_t v;
        v = classify(card);
        return v.luhn_sum;
    endfunction

    function int unsigned pending();
        return pending_verdicts.size();
    endfunction

    function void note_card(bit [luhn_pkg::CARD_W-1:0] card);
        pending_verdicts.push_back(classify(card));
    endfunction

    task report_mismatch(string what, longint unsigned got, longint unsigned want,
                         bit [luhn_pkg::CARD_W-1:0] card);
        $display("mismatch in %s: got %0d, want %0d (card %0d)", what, got, want, card);
        error_count++;
    endtask

    task check_result(logic [luhn_pkg::BRAND_W-1:0] brand, logic luhn_ok,
                      logic [luhn_pkg::COUNT_W-1:0] digit_count,
                      logic [luhn_pkg::SUM_W-1:0] luhn_sum);
        card_verdict_t want;
        if (pending_verdicts.size() == 0) begin
            report_mismatch("result beat with no card pending", 1, 0, '0);
        end else begin
            want = pending_verdicts.pop_front();
            if (brand !== want.brand)
                report_mismatch("brand", brand, want.brand, want.card);
            if (luhn_ok !== want.luhn_ok)
                report_mismatch("luhn_ok", luhn_ok, want.luhn_ok, want.card);
            if (digit_count !== want.digit_count)
                report_mismatch("digit_count", digit_count, want.digit_count, want.card);
            if (luhn_sum !== want.luhn_sum)
                report_mismatch("luhn_sum", luhn_sum, want.luhn_sum, want.card);
        end
    endtask

    task flag_leftover();
        card_verdict_t left;
        while (pending_verdicts.size() != 0) begin
            left = pending_verdicts.pop_front();
            report_mismatch("card never answered", 0, 1, left.card);
        end
    endtask

endclass

module tb_luhn_card_number_classifier;
    import luhn_pkg::*;

    // The settle time at the end covers one pass of a beat through the block.
    localparam int LATENCY_CYCLES = 73;
    localparam int RANDOM_CARDS   = 1900;
    // Even with the longest gaps on both sides of every beat, this limit leaves a wide margin
    // over any correct run.
    localparam int CYCLE_LIMIT    = 1_500_000;
    localparam int DRAIN_LIMIT    = 200_000;
    localparam bit [CARD_W-1:0] CARD_ALL_ONES = '1;

    logic               aclk;
    logic               aresetn;
    logic               s_valid;
    logic               s_ready;
    logic [CARD_W-1:0]  s_card_number;
    logic               m_valid;
    logic               m_ready;
    logic [BRAND_W-1:0] m_brand;
    logic               m_luhn_ok;
    logic [COUNT_W-1:0] m_digit_count;
    logic [SUM_W-1:0]   m_luhn_sum;

    luhn_scoreboard sb;
    // While set, neither side idles, so the block runs back to back.
    bit             no_idle;
    int unsigned    cycle_count;

    luhn_card_number_classifier dut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_card_number (s_card_number),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_brand       (m_brand),
        .m_luhn_ok     (m_luhn_ok),
        .m_digit_count (m_digit_count),
        .m_luhn_sum    (m_luhn_sum)
    );

    initial begin
        aclk = 1'b0;
        forever #4 aclk = ~aclk;
    end

    // Watchdog: a hung handshake or a lost result ends the run here.
    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge aclk);
            cycle_count++;
        end
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

    // Idle stretch length comes from three ascending ranges, picked 80, 16 and 4 percent of the time.
    function automatic int unsigned idle_length();
        int unsigned r;
        r = $urandom_range(99);
        if (r < 80)
            return $urandom_range(3, 1);
        else if (r < 96)
            return $urandom_range(12, 4);
        else
            return $urandom_range(60, 20);
    endfunction

    function automatic bit [63:0] pow10(int unsigned k);
        bit [63:0] v;
        v = 1;
        repeat (k) v = v * 10;
        return v;
    endfunction

    // A random number with exactly ndig decimal digits that still fits the input port.
    function automatic bit [CARD_W-1:0] random_digits(int unsigned ndig);
        bit [63:0] lo;
        bit [63:0] hi;
        bit [63:0] r;
        lo = pow10(ndig - 1);
        hi = pow10(ndig) - 1;
        if (hi > 64'(CARD_ALL_ONES))
            hi = 64'(CARD_ALL_ONES);
        r = {$urandom(), $urandom()};
        return CARD_W'(lo + r % (hi - lo + 1));
    endfunction

    // Builds a number of ndig digits that starts with the given prefix, with random digits
    // in between and a check digit chosen so that the mod-10 check passes or fails.
    function automatic bit [CARD_W-1:0] compose_card(int unsigned prefix, int unsigned plen,
                                                     int unsigned ndig, bit pass);
        bit [63:0]   body;
        int unsigned i;
        int unsigned partial;
        int unsigned check;
        body = 64'(prefix);
        for (i = plen; i + 1 < ndig; i++)
            body = body * 10 + $urandom_range(9);
        // With a trailing zero the check digit sits at an undoubled position, so it adds
        // to the sum as it is.
        partial = sb.luhn_sum_of(CARD_W'(body * 10));
        check   = (10 - partial % 10) % 10;
        if (!pass)
            check = (check + 1 + $urandom_range(8)) % 10;
        return CARD_W'(body * 10 + check);
    endfunction

    // Offers one beat and holds it until the block takes it. Called just after a rising
    // edge; returns at the edge that accepted the beat.
    task automatic send_card(input bit [CARD_W-1:0] card);
        s_valid       <= 1'b1;
        s_card_number <= card;
        do
            @(posedge aclk);
        while (!s_ready);
        sb.note_card(card);
    endtask

    // Unless no_idle is set, drops valid in 35 percent of calls for a random stretch; the payload
    // is scrambled meanwhile so that a block sampling it outside a handshake gets caught.
    task automatic sender_idle();
        if (!no_idle && $urandom_range(99) < 35) begin
            s_valid       <= 1'b0;
            s_card_number <= CARD_W'({$urandom(), $urandom()});
            repeat (idle_length()) @(posedge aclk);
        end
    endtask

    // Holds the sender back until every accepted card has been answered.
    task automatic wait_drained();
        s_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge aclk);
    endtask

    // A random card from one of several families: well-formed numbers of each brand,
    // near misses around the brand prefixes, numbers of every length, raw bit patterns
    // and tiny values.
    function automatic bit [CARD_W-1:0] random_card();
        int unsigned kind;
        int unsigned prefix;
        int unsigned plen;
        int unsigned ndig;
        int unsigned nearby [0:9];
        kind = $urandom_range(99);
        plen = 2;
        if (kind < 45) begin
            case ($urandom_range(2))
                0: begin
                    prefix = ($urandom_range(1) != 0) ? 34 : 37;
                    ndig   = 15;
                end
                1: begin
                    prefix = $urandom_range(55, 51);
                    ndig   = 16;
                end
                default: begin
                    if ($urandom_range(1) != 0) begin
                        prefix = 4;
                        plen   = 1;
                    end else begin
                        prefix = $urandom_range(49, 40);
                    end
                    ndig = ($urandom_range(1) != 0) ? 13 : 16;
                end
            endcase
            // Now and then the length is one off, which must cost the brand.
            if ($urandom_range(4) == 0)
                ndig = ($urandom_range(1) != 0) ? ndig + 1 : ndig - 1;
            if (ndig > 16)
                ndig = 16;
            return compose_card(prefix, plen, ndig, $urandom_range(7) != 0);
        end else if (kind < 60) begin
            nearby = '{33, 35, 36, 38, 50, 56, 39, 30, 57, 60};
            prefix = nearby[$urandom_range(9)];
            return compose_card(prefix, 2, $urandom_range(16, 12), $urandom_range(7) != 0);
        end else if (kind < 80) begin
            return random_digits($urandom_range(17, 1));
        end else if (kind < 92) begin
            return CARD_W'({$urandom(), $urandom()});
        end else begin
            return CARD_W'($urandom_range(99));
        end
    endfunction

    // Result side: checks each beat taken at an edge, then picks the next ready level,
    // one assignment per edge.
    initial begin : result_sink
        int unsigned stall_left;
        stall_left = 0;
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (aresetn && m_valid && m_ready)
                sb.check_result(m_brand, m_luhn_ok, m_digit_count, m_luhn_sum);
            if (!aresetn) begin
                m_ready <= 1'b0;
            end else if (no_idle) begin
                stall_left = 0;
                m_ready <= 1'b1;
            end else if (stall_left > 0) begin
                stall_left--;
                m_ready <= 1'b0;
            end else if ($urandom_range(99) < 70) begin
                m_ready <= 1'b1;
            end else begin
                stall_left = idle_length() - 1;
                m_ready <= 1'b0;
            end
        end
    end

    initial begin : stimulus
        int unsigned i;
        int unsigned waited;
        bit [CARD_W-1:0] directed_cards[$];
        sb      = new();
        no_idle = 1'b0;
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_card_number <= '0;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed part: zero, one-digit and two-digit numbers, the longest supported
        // number, numbers too long for a sum, the top bit and all ones, and each brand
        // with passing and failing checks, wrong lengths and neighboring prefixes.
        directed_cards = '{
            CARD_W'(0), CARD_W'(1), CARD_W'(9), CARD_W'(10), CARD_W'(18), CARD_W'(99),
            CARD_W'(64'd9999999999999999), CARD_W'(64'd10000000000000000),
            CARD_ALL_ONES, CARD_W'(64'd1) << (CARD_W - 1),
            compose_card(34, 2, 15, 1'b1), compose_card(37, 2, 15, 1'b1),
            compose_card(37, 2, 15, 1'b0), compose_card(34, 2, 16, 1'b1),
            compose_card(51, 2, 16, 1'b1), compose_card(55, 2, 16, 1'b1),
            compose_card(55, 2, 16, 1'b0), compose_card(56, 2, 16, 1'b1),
            compose_card(50, 2, 16, 1'b1), compose_card(4, 1, 13, 1'b1),
            compose_card(4, 1, 16, 1'b1), compose_card(4, 1, 16, 1'b0),
            compose_card(4, 1, 15, 1'b1), compose_card(35, 2, 15, 1'b1)
        };
        foreach (directed_cards[k]) begin
            send_card(directed_cards[k]);
            sender_idle();
        end
        wait_drained();

        // Random part. Every few hundred beats both sides run without idling for a while,
        // and halfway through the sender waits for the block to empty once more.
        for (i = 0; i < RANDOM_CARDS; i++) begin
            if (i % 400 == 200)
                no_idle = 1'b1;
            else if (i % 400 == 300)
                no_idle = 1'b0;
            if (i == RANDOM_CARDS / 2)
                wait_drained();
            send_card(random_card());
            sender_idle();
        end
        no_idle = 1'b0;
        s_valid <= 1'b0;

        waited = 0;
        while (sb.pending() != 0 && waited < DRAIN_LIMIT) begin
            @(posedge aclk);
            waited++;
        end
        sb.flag_leftover();
        // Any stray result beat would show up within one more pass through the block.
        repeat (LATENCY_CYCLES + 20) @(posedge aclk);

        if (sb.error_count == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
